>>> rtl/mcn_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the mesh cell normalizer
// no dependencies; used by every module in rtl but mcn_checker

package mcn_pkg;

  localparam int MCN_INDEX_WIDTH      = 32;
  localparam int MCN_MAX_CELL_INDICES = 255;
  localparam int MCN_QUEUE_DEPTH      = 4;
  localparam int MCN_MAX_RESULTS      = 8;
  localparam int MCN_BUF_DEPTH        = 8;

  // legacy shape codes
  localparam logic [7:0] SH_VERTEX      = 8'd1;
  localparam logic [7:0] SH_POLY_VERTEX = 8'd2;
  localparam logic [7:0] SH_LINE        = 8'd3;
  localparam logic [7:0] SH_POLY_LINE   = 8'd4;
  localparam logic [7:0] SH_TRIANGLE    = 8'd5;
  localparam logic [7:0] SH_STRIP       = 8'd6;
  localparam logic [7:0] SH_POLYGON     = 8'd7;
  localparam logic [7:0] SH_PIXEL       = 8'd8;
  localparam logic [7:0] SH_QUAD        = 8'd9;
  localparam logic [7:0] SH_TETRA       = 8'd10;
  localparam logic [7:0] SH_VOXEL       = 8'd11;
  localparam logic [7:0] SH_HEXAHEDRON  = 8'd12;
  localparam logic [7:0] SH_WEDGE       = 8'd13;
  localparam logic [7:0] SH_PYRAMID     = 8'd14;

  // one classified input word and the results it causes
  typedef struct packed {
    logic [3:0]                             nres;
    logic [3:0]                             shape;
    logic [7:0]                             count;
    logic [31:0]                            src_cell;
    logic                                   end_last;
    logic                                   bad;
    logic [MCN_MAX_RESULTS-1:0][31:0]       idx;
  } mcn_job_t;

endpackage

>>> rtl/mcn_queue.sv
`timescale 1ns / 1ps
// short job queue between front and back
// depends on mcn_pkg

module mcn_queue #(
  parameter int DEPTH = mcn_pkg::MCN_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mcn_pkg::mcn_job_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output mcn_pkg::mcn_job_t pop_data
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  mcn_pkg::mcn_job_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full     = (cnt_r == CntW'(DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/mcn_front.sv
`timescale 1ns / 1ps
// front end: accepts index words, tracks cell position, classifies shapes
// depends on mcn_pkg; feeds mcn_queue

module mcn_front #(
  parameter int INDEX_WIDTH      = mcn_pkg::MCN_INDEX_WIDTH,
  parameter int MAX_CELL_INDICES = mcn_pkg::MCN_MAX_CELL_INDICES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_shape,
  input  logic [7:0]        in_count,
  input  logic [31:0]       in_index,
  input  logic              q_full,
  output logic              q_push,
  output mcn_pkg::mcn_job_t q_data
);

  localparam logic [31:0] IdxMask = (INDEX_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                    32'((64'd1 << INDEX_WIDTH) - 64'd1);
  localparam int BufAw = $clog2(mcn_pkg::MCN_BUF_DEPTH);

  logic [7:0]  pos_r, pos_nxt;
  logic [31:0] cell_r, cell_nxt;
  logic [31:0] ibuf_r [mcn_pkg::MCN_BUF_DEPTH];
  logic [31:0] prev1_r, prev2_r;
  logic [7:0]  cnt_clamp, cnt_eff;
  logic [31:0] idx_m;
  logic        last, accept, has_res;
  mcn_pkg::mcn_job_t job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign idx_m    = in_index & IdxMask;
  assign q_push   = accept && has_res;
  assign q_data   = job;

  always_comb begin
    cnt_clamp = (32'(in_count) > 32'(MAX_CELL_INDICES)) ? 8'(MAX_CELL_INDICES) : in_count;
    cnt_eff   = (cnt_clamp == 8'd0) ? 8'd1 : cnt_clamp;
    last      = ({1'b0, pos_r} + 9'd1) >= {1'b0, cnt_eff};
  end

  // classify the word into the results it causes
  always_comb begin
    job          = '0;
    has_res      = 1'b0;
    job.src_cell = cell_r;
    job.shape    = in_shape[3:0];
    job.count    = cnt_eff;
    job.nres     = 4'd1;
    job.end_last = last;
    job.idx[0]   = idx_m;
    case (in_shape) inside
      mcn_pkg::SH_VERTEX, mcn_pkg::SH_LINE, mcn_pkg::SH_TRIANGLE, mcn_pkg::SH_QUAD,
      mcn_pkg::SH_TETRA, mcn_pkg::SH_HEXAHEDRON, mcn_pkg::SH_WEDGE,
      mcn_pkg::SH_PYRAMID, mcn_pkg::SH_POLY_LINE: begin
        has_res = 1'b1;
      end
      mcn_pkg::SH_POLYGON: begin
        has_res = 1'b1;
        if (cnt_eff == 8'd3) begin
          job.shape = mcn_pkg::SH_TRIANGLE[3:0];
        end else if (cnt_eff == 8'd4) begin
          job.shape = mcn_pkg::SH_QUAD[3:0];
        end
      end
      mcn_pkg::SH_POLY_VERTEX: begin
        has_res      = 1'b1;
        job.shape    = mcn_pkg::SH_VERTEX[3:0];
        job.count    = 8'd1;
        job.end_last = 1'b1;
      end
      mcn_pkg::SH_STRIP: begin
        has_res      = (pos_r >= 8'd2);
        job.shape    = mcn_pkg::SH_TRIANGLE[3:0];
        job.count    = 8'd3;
        job.nres     = 4'd3;
        job.end_last = 1'b1;
        if (pos_r[0]) begin
          job.idx[0] = prev2_r;
          job.idx[1] = prev1_r;
          job.idx[2] = idx_m;
        end else begin
          job.idx[0] = idx_m;
          job.idx[1] = prev1_r;
          job.idx[2] = prev2_r;
        end
      end
      mcn_pkg::SH_PIXEL: begin
        has_res      = (pos_r == 8'd3);
        job.shape    = mcn_pkg::SH_QUAD[3:0];
        job.count    = 8'd4;
        job.nres     = 4'd4;
        job.end_last = 1'b1;
        job.idx[0]   = ibuf_r[0];
        job.idx[1]   = ibuf_r[1];
        job.idx[2]   = idx_m;
        job.idx[3]   = ibuf_r[2];
      end
      mcn_pkg::SH_VOXEL: begin
        has_res      = (pos_r == 8'd7);
        job.shape    = mcn_pkg::SH_HEXAHEDRON[3:0];
        job.count    = 8'd8;
        job.nres     = 4'd8;
        job.end_last = 1'b1;
        job.idx[0]   = ibuf_r[0];
        job.idx[1]   = ibuf_r[1];
        job.idx[2]   = ibuf_r[3];
        job.idx[3]   = ibuf_r[2];
        job.idx[4]   = ibuf_r[4];
        job.idx[5]   = ibuf_r[5];
        job.idx[6]   = idx_m;
        job.idx[7]   = ibuf_r[6];
      end
      default: begin
        has_res      = (pos_r == 8'd0);
        job.shape    = '0;
        job.count    = '0;
        job.end_last = 1'b0;
        job.bad      = 1'b1;
        job.idx[0]   = '0;
      end
    endcase
  end

  always_comb begin
    pos_nxt  = pos_r;
    cell_nxt = cell_r;
    if (accept) begin
      if (last) begin
        pos_nxt  = '0;
        cell_nxt = cell_r + 32'd1;
      end else begin
        pos_nxt  = pos_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      cell_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      cell_r <= cell_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ibuf_r[pos_r[BufAw-1:0]] <= idx_m;
      prev1_r                  <= idx_m;
      prev2_r                  <= prev1_r;
    end
  end

endmodule

>>> rtl/mcn_back.sv
`timescale 1ns / 1ps
// back end: plays queued jobs out one result word per cycle while out_ready is high
// depends on mcn_pkg; fed by mcn_queue

module mcn_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  mcn_pkg::mcn_job_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_shape,
  output logic [7:0]        out_count,
  output logic [31:0]       out_index,
  output logic [31:0]       out_cell,
  output logic              out_cell_end,
  output logic              out_run_last,
  output logic              out_bad
);

  logic              act_r, act_nxt;
  logic [3:0]        rem_r, rem_nxt;
  mcn_pkg::mcn_job_t job_r, job_nxt;
  logic              take, final_word, advance;

  assign take       = act_r && out_ready;
  assign final_word = (rem_r == 4'd1);
  assign advance    = !act_r || (take && final_word);
  assign q_pop      = advance && q_valid;

  assign out_valid    = act_r;
  assign out_shape    = job_r.shape;
  assign out_count    = job_r.count;
  assign out_index    = job_r.idx[0];
  assign out_cell     = job_r.src_cell;
  assign out_cell_end = job_r.end_last && final_word;
  assign out_run_last = final_word;
  assign out_bad      = job_r.bad;

  always_comb begin
    act_nxt = act_r;
    rem_nxt = rem_r;
    job_nxt = job_r;
    if (q_pop) begin
      act_nxt = 1'b1;
      rem_nxt = q_data.nres;
      job_nxt = q_data;
    end else if (advance) begin
      act_nxt = 1'b0;
    end else if (take) begin
      rem_nxt = rem_r - 4'd1;
      for (int i = 0; i < mcn_pkg::MCN_MAX_RESULTS - 1; i++) begin
        job_nxt.idx[i] = job_r.idx[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      rem_r <= '0;
    end else begin
      act_r <= act_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

endmodule

>>> rtl/mesh_cell_normalizer_top.sv
`timescale 1ns / 1ps
// path: an accepted word with results is written to the job queue, then the back end's job register
// throughput: one index word per cycle while the queue is not full; the output port moves
// one result word per cycle while out_tready is high; a strip triangle gives 3 words,
// a pixel 4 and a voxel 8; the job queue between front and back absorbs these bursts
// reset: synchronous active-low rst_n clears position, cell number and queue;
// the index buffer needs no clearing pass

module mesh_cell_normalizer_top #(
  parameter int INDEX_WIDTH      = mcn_pkg::MCN_INDEX_WIDTH,
  parameter int MAX_CELL_INDICES = mcn_pkg::MCN_MAX_CELL_INDICES,
  parameter int QUEUE_DEPTH      = mcn_pkg::MCN_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // index_count, point_index
  input  logic [7:0]  in_tuser,   // shape_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // out_shape, out_count, out_index, source_cell, zero pad
  output logic [1:0]  out_tuser,  // cell_end, bad_shape
  output logic        out_tlast
);

  mcn_pkg::mcn_job_t push_data, pop_data;
  logic              q_push, q_full, q_pop, q_valid;
  logic [3:0]        o_shape;
  logic [7:0]        o_count;
  logic [31:0]       o_index, o_cell;
  logic              o_end, o_last, o_bad;

  mcn_front #(
    .INDEX_WIDTH      (INDEX_WIDTH),
    .MAX_CELL_INDICES (MAX_CELL_INDICES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_shape (in_tuser),
    .in_count (in_tdata[7:0]),
    .in_index (in_tdata[39:8]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  mcn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (pop_data)
  );

  mcn_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_data       (pop_data),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_shape    (o_shape),
    .out_count    (o_count),
    .out_index    (o_index),
    .out_cell     (o_cell),
    .out_cell_end (o_end),
    .out_run_last (o_last),
    .out_bad      (o_bad)
  );

  assign out_tdata = {4'd0, o_cell, o_index, o_count, o_shape};
  assign out_tuser = {o_bad, o_end};
  assign out_tlast = o_last;

endmodule

>>> rtl/mcn_checker.sv
`timescale 1ns / 1ps
// port-level checks on the mesh cell normalizer
// depends on mesh_cell_normalizer_top; attached by the bind below

module mcn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result word changed");

  // after reset the block is empty and ready
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not empty after reset");

  // bad shape word is alone in its run and carries zero payload
  a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && !out_tuser[0] && out_tdata[43:0] == 44'd0)
    else $error("malformed bad shape word");

  // a run continues right after a non-final word and keeps its source cell
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid
      && out_tdata[75:44] == $past(out_tdata[75:44]))
    else $error("run broken or source cell changed");

endmodule

bind mesh_cell_normalizer_top mcn_checker u_mcn_checker (.*);

>>> sim/mesh_cell_normalizer_top_test.sv
`timescale 1ns / 1ps
// self-checking bench for mesh_cell_normalizer_top: directed cells, then random cell streams
// a scoreboard class predicts every result word; needs rtl/mcn_pkg.sv and the rtl top

module mesh_cell_normalizer_top_test;

  localparam int TOTAL_WORDS = 220;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [3:0]  shape;
    logic [7:0]  count;
    logic [31:0] index;
    logic [31:0] src_cell;
    logic        cend;
    logic        rlast;
    logic        bad;
  } cell_word_t;

  class cell_scoreboard;
    bit [7:0]    pos;
    bit [31:0]   cell_num;
    bit [31:0]   ibuf[8];
    int unsigned corner[8] = '{0, 1, 3, 2, 4, 5, 7, 6};
    cell_word_t  due[$];
    int          errors;
    int          words_in;
    int          words_out;

    function void add(logic [3:0] shape, logic [7:0] count, logic [31:0] index,
                      logic cend, logic bad);
      cell_word_t w;
      w.shape    = shape;
      w.count    = count;
      w.index    = index;
      w.src_cell = cell_num;
      w.cend     = cend;
      w.rlast    = 1'b0;
      w.bad      = bad;
      due.insert(due.size(), w);
    endfunction

    function void note_input(logic [7:0] shape, logic [7:0] count, logic [31:0] index);
      logic [7:0]  eff;
      bit          last;
      int          n0;
      int          p;
      logic [3:0]  s;
      logic [31:0] a, b, c;
      eff = (count == 8'd0) ? 8'd1 : count;
      p = pos;
      last = (p + 1 >= eff);
      ibuf[p % 8] = index;
      n0 = due.size();
      words_in++;
      case (shape)
        mcn_pkg::SH_VERTEX, mcn_pkg::SH_LINE, mcn_pkg::SH_TRIANGLE, mcn_pkg::SH_QUAD,
        mcn_pkg::SH_TETRA, mcn_pkg::SH_HEXAHEDRON, mcn_pkg::SH_WEDGE,
        mcn_pkg::SH_PYRAMID, mcn_pkg::SH_POLY_LINE: begin
          add(shape[3:0], eff, index, last, 1'b0);
        end
        mcn_pkg::SH_POLYGON: begin
          s = (eff == 8'd3) ? mcn_pkg::SH_TRIANGLE[3:0] :
              (eff == 8'd4) ? mcn_pkg::SH_QUAD[3:0] : mcn_pkg::SH_POLYGON[3:0];
          add(s, eff, index, last, 1'b0);
        end
        mcn_pkg::SH_POLY_VERTEX: begin
          add(mcn_pkg::SH_VERTEX[3:0], 8'd1, index, 1'b1, 1'b0);
        end
        mcn_pkg::SH_STRIP: begin
          if (p >= 2) begin
            a = ibuf[(p - 2) % 8];
            b = ibuf[(p - 1) % 8];
            c = ibuf[p % 8];
            // winding alternates from one triangle to the next
            if ((p - 2) % 2 == 1) begin
              add(mcn_pkg::SH_TRIANGLE[3:0], 8'd3, a, 1'b0, 1'b0);
              add(mcn_pkg::SH_TRIANGLE[3:0], 8'd3, b, 1'b0, 1'b0);
              add(mcn_pkg::SH_TRIANGLE[3:0], 8'd3, c, 1'b1, 1'b0);
            end else begin
              add(mcn_pkg::SH_TRIANGLE[3:0], 8'd3, c, 1'b0, 1'b0);
              add(mcn_pkg::SH_TRIANGLE[3:0], 8'd3, b, 1'b0, 1'b0);
              add(mcn_pkg::SH_TRIANGLE[3:0], 8'd3, a, 1'b1, 1'b0);
            end
          end
        end
        mcn_pkg::SH_PIXEL: begin
          if (p == 3)
            for (int k = 0; k < 4; k++)
              add(mcn_pkg::SH_QUAD[3:0], 8'd4, ibuf[corner[k]], k == 3, 1'b0);
        end
        mcn_pkg::SH_VOXEL: begin
          if (p == 7)
            for (int k = 0; k < 8; k++)
              add(mcn_pkg::SH_HEXAHEDRON[3:0], 8'd8, ibuf[corner[k]], k == 7, 1'b0);
        end
        default: begin
          if (p == 0)
            add(4'd0, 8'd0, 32'd0, 1'b0, 1'b1);
        end
      endcase
      if (due.size() > n0)
        due[due.size() - 1].rlast = 1'b1;
      if (last) begin
        pos = 8'd0;
        cell_num = cell_num + 32'd1;
      end else begin
        pos = pos + 8'd1;
      end
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(cell_word_t got);
      cell_word_t exp_w;
      words_out++;
      if (due.size() == 0) begin
        $error("result word with nothing expected: index 0x%0h cell %0d",
               got.index, got.src_cell);
        errors++;
        return;
      end
      exp_w = due.pop_front();
      compare("bad_shape", exp_w.bad, got.bad);
      compare("source_cell", exp_w.src_cell, got.src_cell);
      compare("run_last", exp_w.rlast, got.rlast);
      // for an unsupported shape the remaining fields carry no meaning
      if (!exp_w.bad) begin
        compare("out_shape", exp_w.shape, got.shape);
        compare("out_count", exp_w.count, got.count);
        compare("out_index", exp_w.index, got.index);
        compare("cell_end", exp_w.cend, got.cend);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // index_count, point_index
  logic [7:0]  in_tuser;   // shape_code
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;  // out_shape, out_count, out_index, source_cell, zero pad
  logic [1:0]  out_tuser;  // cell_end, bad_shape
  logic        out_tlast;

  cell_scoreboard sb;
  bit             calm;
  int             cycles;
  int             cells_sent;

  mesh_cell_normalizer_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    sb = new();
    calm = 1'b0;
    cycles = 0;
    cells_sent = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, sb.due.size());
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random back-pressure, none while calm
  always @(posedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk) begin
    cell_word_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.shape    = out_tdata[3:0];
      got.count    = out_tdata[11:4];
      got.index    = out_tdata[43:12];
      got.src_cell = out_tdata[75:44];
      got.cend     = out_tuser[0];
      got.bad      = out_tuser[1];
      got.rlast    = out_tlast;
      sb.check_result(got);
    end
  end

  task automatic send_word(logic [7:0] shape, logic [7:0] count, logic [31:0] index);
    if (!calm && $urandom_range(0, 99) < 25) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {index, count};
    in_tuser  <= shape;
    do @(posedge clk); while (!in_tready);
    sb.note_input(shape, count, index);
  endtask

  task automatic send_cell(logic [7:0] shape, logic [7:0] count);
    for (int i = 0; i < count; i++)
      send_word(shape, count, $urandom());
    cells_sent++;
  endtask

  task automatic random_cell();
    int          r;
    logic [7:0]  shape;
    logic [7:0]  count;
    int          words;
    r = $urandom_range(0, 17);
    if (r == 0 || r == 15)
      shape = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(15, 255));
    else if (r == 16)
      shape = mcn_pkg::SH_VOXEL;
    else if (r == 17)
      shape = mcn_pkg::SH_STRIP;
    else
      shape = 8'(r);
    case (shape)
      mcn_pkg::SH_STRIP:       count = 8'($urandom_range(3, 10));
      mcn_pkg::SH_PIXEL:       count = ($urandom_range(0, 4) == 0) ?
                                       8'($urandom_range(1, 6)) : 8'd4;
      mcn_pkg::SH_VOXEL:       count = ($urandom_range(0, 4) == 0) ?
                                       8'($urandom_range(1, 10)) : 8'd8;
      mcn_pkg::SH_POLYGON:     count = 8'($urandom_range(2, 6));
      mcn_pkg::SH_POLY_VERTEX: count = 8'($urandom_range(1, 6));
      default:                 count = 8'($urandom_range(1, 8));
    endcase
    // a few cells are cut short so the next one starts mid-cell
    words = ($urandom_range(0, 19) == 0) ? $urandom_range(1, count) : count;
    for (int i = 0; i < words; i++) begin
      if ($urandom_range(0, 99) < 8)
        send_word(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)), $urandom());
      else
        send_word(shape, count, $urandom());
    end
    cells_sent++;
  endtask

  initial begin
    int sent;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: index and count extremes, every conversion, unsupported codes
    send_word(mcn_pkg::SH_VERTEX, 8'd1, 32'h0000_0000);
    send_word(mcn_pkg::SH_HEXAHEDRON, 8'd255, 32'hFFFF_FFFF);
    send_word(mcn_pkg::SH_LINE, 8'd1, 32'hFFFF_FFFF);
    send_cell(mcn_pkg::SH_POLY_VERTEX, 8'd2);
    send_word(mcn_pkg::SH_POLYGON, 8'd3, 32'h0000_0003);
    send_word(mcn_pkg::SH_POLYGON, 8'd4, 32'h0000_0004);
    send_word(mcn_pkg::SH_POLYGON, 8'd2, 32'h0000_0005);
    send_cell(mcn_pkg::SH_STRIP, 8'd5);
    send_cell(mcn_pkg::SH_PIXEL, 8'd4);
    send_cell(mcn_pkg::SH_PIXEL, 8'd2);
    send_cell(mcn_pkg::SH_VOXEL, 8'd8);
    send_word(8'd0, 8'd1, 32'h1234_5678);
    send_word(8'd255, 8'd2, 32'hFFFF_FFFF);
    send_word(8'd255, 8'd2, 32'h0000_0000);

    sent = sb.words_in;
    while (sent < TOTAL_WORDS) begin
      calm = (sent >= 100 && sent < 160);
      random_cell();
      sent = sb.words_in;
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    while (sb.due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("ran %0d index words in about %0d cells, %0d result words checked",
             sb.words_in, cells_sent, sb.words_out);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> mesh_cell_normalizer_top.f
rtl/mcn_pkg.sv
rtl/mcn_queue.sv
rtl/mcn_front.sv
rtl/mcn_back.sv
rtl/mesh_cell_normalizer_top.sv
rtl/mcn_checker.sv
sim/mesh_cell_normalizer_top_test.sv
